// File: sv/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder: shared types, constants and
// the per-length offset table. No dependencies.
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 32;
  localparam int unsigned CntW  = 3;

  localparam logic [ByteW-1:0] AsciiMax  = 8'h7F;
  localparam logic [CpW-1:0]   SpaceCode = 32'h0000_0020;

  // Decoder state carried from item to item
  typedef struct packed {
    logic [CpW-1:0]  acc;
    logic [CntW-1:0] remaining;
    logic [CntW-1:0] seq_len;
  } dec_state_t;

  // Result of one decode step
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           malformed;
  } dec_result_t;

  // Offset to strip the lead and continuation marker bits, by trailing count
  function automatic logic [CpW-1:0] offset_for_len(input logic [CntW-1:0] len);
    logic [CpW-1:0] off;
    begin
      unique case (len)
        3'd1:    off = 32'h0000_3080;
        3'd2:    off = 32'h000E_2080;
        3'd3:    off = 32'h03C8_2080;
        3'd4:    off = 32'hFA08_2080;
        3'd5:    off = 32'h8208_2080;
        default: off = '0;
      endcase
      return off;
    end
  endfunction

  // Trailing byte count from a lead byte (C0..FD)
  function automatic logic [CntW-1:0] trailing_for_lead(input logic [ByteW-1:0] b);
    logic [CntW-1:0] n;
    begin
      if (b <= 8'hDF)      n = 3'd1;
      else if (b <= 8'hEF) n = 3'd2;
      else if (b <= 8'hF7) n = 3'd3;
      else if (b <= 8'hFB) n = 3'd4;
      else                 n = 3'd5;
      return n;
    end
  endfunction

endpackage

// File: sv/u8d_step.sv
// One decode step: next state and optional result from the current state
// and one byte. Combinational; uses u8d_pkg.
module u8d_step (
  input  u8d_pkg::dec_state_t       state_i,
  input  logic [u8d_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  output u8d_pkg::dec_state_t       state_o,
  output u8d_pkg::dec_result_t      result_o
);

  logic [u8d_pkg::CpW-1:0]  sum;
  logic [u8d_pkg::CpW-1:0]  lead_acc;
  logic [u8d_pkg::CntW-1:0] lead_len;

  assign sum      = state_i.acc + {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_i};
  assign lead_acc = {{(u8d_pkg::CpW-u8d_pkg::ByteW-6){1'b0}}, byte_i, 6'b0};
  assign lead_len = u8d_pkg::trailing_for_lead(byte_i);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.remaining == '0) begin
      if (byte_i <= u8d_pkg::AsciiMax) begin
        result_o.emit       = 1'b1;
        result_o.code_point = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_i};
      end else if (byte_i[7:6] != 2'b11) begin
        // stray continuation: drop unless it ends the buffer
        result_o.emit       = last_i;
        result_o.code_point = u8d_pkg::SpaceCode;
        result_o.malformed  = 1'b1;
      end else if (byte_i[7:1] == 7'h7F) begin
        result_o.emit       = 1'b1;
        result_o.code_point = u8d_pkg::SpaceCode;
        result_o.malformed  = 1'b1;
      end else if (last_i) begin
        result_o.emit       = 1'b1;
        result_o.code_point = lead_acc - u8d_pkg::offset_for_len(lead_len);
        state_o             = '0;
      end else begin
        state_o.acc       = lead_acc;
        state_o.remaining = lead_len;
        state_o.seq_len   = lead_len;
      end
    end else if (state_i.remaining == 3'd1) begin
      result_o.emit       = 1'b1;
      result_o.code_point = sum - u8d_pkg::offset_for_len(state_i.seq_len);
      state_o             = '0;
    end else if (last_i) begin
      // sequence cut short: emit the shifted partial value
      result_o.emit       = 1'b1;
      result_o.code_point = {sum[u8d_pkg::CpW-7:0], 6'b0}
                            - u8d_pkg::offset_for_len(state_i.seq_len);
      state_o             = '0;
    end else begin
      state_o.acc       = {sum[u8d_pkg::CpW-7:0], 6'b0};
      state_o.remaining = state_i.remaining - 3'd1;
    end
  end

endmodule

// File: sv/u8d_out_reg.sv
// Result register for the master side: holds one item until taken.
// Uses u8d_pkg for widths.
module u8d_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [u8d_pkg::CpW-1:0]  code_point_i,
  input  logic                     malformed_i,
  input  logic                     ready_i,
  output logic                     valid_o,
  output logic [u8d_pkg::CpW-1:0]  code_point_o,
  output logic                     malformed_o
);

  logic                    valid_q, valid_d;
  logic [u8d_pkg::CpW-1:0] cp_q;
  logic                    bad_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) valid_d = 1'b0;
    if (load_i)  valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cp_q  <= code_point_i;
      bad_q <= malformed_i;
    end
  end

  assign valid_o      = valid_q;
  assign code_point_o = cp_q;
  assign malformed_o  = bad_q;

endmodule

// File: sv/utf8_byte_stream_decoder_top.sv
// Top level of the UTF-8 byte stream decoder: input register, decoder
// state and result register. Uses u8d_pkg, u8d_step and u8d_out_reg.
//
//   channel  dir  tdata              tuser       tlast
//   s_axis   in   [7:0] in_byte      -           end_of_buffer
//   m_axis   out  [31:0] code_point  malformed   -
//
// One byte per cycle while the master side does not stall; the result of a byte is
// loaded into the result register from the input register through one decode step.
// Reset clears the decoder state and both valid flags.
// A stall on the master side holds the result; the input register keeps
// taking bytes while the step can advance or yields no result.
module utf8_byte_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] code_point
  output logic        m_axis_tuser    // [0] malformed
);

  logic                      in_valid_q, in_valid_d;
  logic [u8d_pkg::ByteW-1:0] in_byte_q;
  logic                      in_last_q;
  u8d_pkg::dec_state_t       state_q, state_d, state_next;
  u8d_pkg::dec_result_t      result;
  logic                      advance;
  logic                      s_fire;

  u8d_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_next),
    .result_o (result)
  );

  // advance the held byte when the result register is free or being drained, or the byte yields no result
  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready || !result.emit);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) in_valid_d = 1'b0;
    if (s_fire)  in_valid_d = 1'b1;
    state_d = advance ? state_next : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  u8d_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && result.emit),
    .code_point_i (result.code_point),
    .malformed_i  (result.malformed),
    .ready_i      (m_axis_tready),
    .valid_o      (m_axis_tvalid),
    .code_point_o (m_axis_tdata),
    .malformed_o  (m_axis_tuser)
  );

endmodule

// File: test/u8d_checker.sv
// Checker for the UTF-8 byte stream decoder: predicts the result items from the
// accepted input items and compares each result item in order.
// Depends on u8d_pkg for the space code and the ASCII limit.
module u8d_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // end_of_buffer
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [31:0] code_point
  input  logic        m_axis_tuser_i,   // [0] malformed
  output logic [31:0] fail_count_o,
  output logic [31:0] pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] code_point;
    logic        malformed;
  } code_item_t;

  code_item_t  code_points_due[$];
  logic [31:0] acc;
  logic [2:0]  bytes_left;
  logic [2:0]  trail_len;
  logic [31:0] mismatches;
  logic [31:0] outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic logic [2:0] trailing_count(input logic [7:0] lead);
    if (!lead[5]) return 3'd1;
    if (!lead[4]) return 3'd2;
    if (!lead[3]) return 3'd3;
    if (!lead[2]) return 3'd4;
    return 3'd5;
  endfunction

  // Marker bits of the lead and continuation bytes, folded into one constant
  function automatic logic [31:0] marker_offset(input logic [2:0] len);
    case (len)
      3'd1:    return 32'h0000_3080;
      3'd2:    return 32'h000E_2080;
      3'd3:    return 32'h03C8_2080;
      3'd4:    return 32'hFA08_2080;
      3'd5:    return 32'h8208_2080;
      default: return 32'h0;
    endcase
  endfunction

  task automatic close_sequence(output code_item_t res);
    res.code_point = acc - marker_offset(trail_len);
    res.malformed  = 1'b0;
    acc        = '0;
    bytes_left = '0;
    trail_len  = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last,
                             output logic has_result, output code_item_t res);
    has_result = 1'b0;
    res        = '0;
    if (bytes_left == 3'd0) begin
      if (b <= u8d_pkg::AsciiMax) begin
        has_result = 1'b1;
        res        = '{code_point: {24'h0, b}, malformed: 1'b0};
      end else if (b[7:6] != 2'b11) begin
        // stray continuation: silent unless it ends the buffer
        if (last) begin
          has_result = 1'b1;
          res        = '{code_point: u8d_pkg::SpaceCode, malformed: 1'b1};
        end
      end else if (b[7:1] == 7'h7F) begin
        has_result = 1'b1;
        res        = '{code_point: u8d_pkg::SpaceCode, malformed: 1'b1};
      end else begin
        trail_len  = trailing_count(b);
        bytes_left = trail_len;
        acc        = {18'h0, b, 6'h0};
        if (last) begin
          has_result = 1'b1;
          close_sequence(res);
        end
      end
    end else if (bytes_left == 3'd1) begin
      acc        = acc + {24'h0, b};
      has_result = 1'b1;
      close_sequence(res);
    end else begin
      acc        = (acc + {24'h0, b}) << 6;
      bytes_left = bytes_left - 3'd1;
      if (last) begin
        has_result = 1'b1;
        close_sequence(res);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic       has_result;
    code_item_t want;
    code_item_t got;
    if (!rst_ni) begin
      acc         = '0;
      bytes_left  = '0;
      trail_len   = '0;
      mismatches  = '0;
      outstanding = '0;
      code_points_due.delete();
    end else begin
      // check the result first: a byte taken now cannot show up at this edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{code_point: m_axis_tdata_i, malformed: m_axis_tuser_i};
        if (code_points_due.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected result item code_point %h malformed %b",
                   $time, got.code_point, got.malformed);
        end else begin
          want        = code_points_due.pop_front();
          outstanding = outstanding - 1;
          if (got.code_point !== want.code_point) begin
            mismatches = mismatches + 1;
            $display("%0t: code_point expected %h actual %h",
                     $time, want.code_point, got.code_point);
          end
          if (got.malformed !== want.malformed) begin
            mismatches = mismatches + 1;
            $display("%0t: malformed expected %b actual %b",
                     $time, want.malformed, got.malformed);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        decode_byte(s_axis_tdata_i, s_axis_tlast_i, has_result, want);
        if (has_result) begin
          code_points_due.push_back(want);
          outstanding = outstanding + 1;
        end
      end
    end
  end

endmodule

// File: test/tb_utf8_byte_stream_decoder_top.sv
// Testbench top for the UTF-8 byte stream decoder: clock, reset, byte stimulus
// and back-pressure, verdict from the failure count of u8d_checker.
// Depends on utf8_byte_stream_decoder_top, u8d_checker and u8d_pkg.
module tb_utf8_byte_stream_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 600;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic [31:0] fail_count;
  logic [31:0] pending;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 88;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  utf8_byte_stream_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  u8d_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_utf8_byte_stream_decoder_top: FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until taken; drop valid only across a gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // One noise byte, or one sequence that is whole or cut short by the end mark.
  // A noise lead byte without the end mark opens a sequence that the next units
  // fill in.
  task automatic send_random_unit();
    int unsigned kind;
    int unsigned len;
    int unsigned stop;
    int unsigned k;
    logic [7:0]  b;
    logic        last;
    kind = $urandom_range(99);
    if (kind < 25) begin
      b    = 8'($urandom_range(255));
      last = 1'($urandom_range(1));
      send_byte(b, last);
      // a stray continuation without the end mark is ignored by the block
      if (!(b[7:6] == 2'b10 && !last)) items_sent++;
    end else begin
      len  = $urandom_range(5, 1);
      stop = (kind < 40) ? $urandom_range(len - 1, 0) : len;
      for (k = 0; k <= stop; k++) begin
        if (k == 0) begin
          case (len)
            1:       b = {3'b110, 5'($urandom)};
            2:       b = {4'b1110, 4'($urandom)};
            3:       b = {5'b11110, 3'($urandom)};
            4:       b = {6'b111110, 2'($urandom)};
            default: b = {7'b1111110, 1'($urandom)};
          endcase
        end else if ($urandom_range(9) != 0) begin
          b = {2'b10, 6'($urandom)};
        end else begin
          b = 8'($urandom_range(255));
        end
        if (k == stop) last = (stop < len) ? 1'b1 : ($urandom_range(3) == 0);
        else           last = 1'b0;
        send_byte(b, last);
        items_sent++;
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned goal;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII extremes, stray continuations, forbidden bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // whole sequences of three, four and five trailing bytes
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0); send_byte(8'h88, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hFD, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    // end mark on a lead byte, then in the middle of a sequence
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b1);
    // ASCII taken as a trailing byte
    send_byte(8'hDF, 1'b0); send_byte(8'h41, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 35; recv_idle_pct = 88; end
        1:       begin send_idle_pct = 88; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      goal = items_sent + PhaseItems;
      while (items_sent < goal) send_random_unit();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_utf8_byte_stream_decoder_top: PASS");
    end else begin
      $display("tb_utf8_byte_stream_decoder_top: FAIL");
    end
    $finish;
  end

endmodule
